// ----- sv/nearest_point_top_k_select_macros.svh -----
// Assertion macros used by the RTL file nearest_point_top_k_select.sv.
// Each macro expects signals named clk and rst_n in the using module.
`ifndef NEAREST_POINT_TOP_K_SELECT_MACROS_SVH
`define NEAREST_POINT_TOP_K_SELECT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NPTK_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define NPTK_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/nptk_pkg.sv -----
`default_nettype none

package nptk_pkg;

  localparam int TABLE_DEPTH = 4096;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int MAX_COPIES  = 8;
  localparam int SLOT_W      = $clog2(MAX_COPIES);
  localparam int REP_W       = 4;
  localparam int POINT_W     = 64;
  localparam int COORD_W     = 32;
  localparam int SERVER_W    = 16;
  localparam int DIST_W      = 65;
  localparam int ENTRY_W     = SERVER_W + POINT_W;

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  typedef logic [POINT_W-1:0]  point_t;
  typedef logic [COORD_W-1:0]  coord_t;
  typedef logic [SERVER_W-1:0] server_t;
  typedef logic [DIST_W-1:0]   dist_t;
  typedef logic [CNT_W-1:0]    count_t;
  typedef logic [SLOT_W-1:0]   slot_t;
  typedef logic [REP_W-1:0]    rep_t;

endpackage

`default_nettype wire

// ----- sv/nptk_ram.sv -----
`default_nettype none

module nptk_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- sv/nearest_point_top_k_select.sv -----
// Channel   Direction  Handshake               Payload
// in_       input      in_valid / in_stall     action, entry index, server, points, replication
// out_      output     out_valid / out_stall   server_index, found, rank, last
// cfg_      input      cfg_we                  entries_in_use
//
// A load writes one table entry. A query covers n = min(entries_in_use, 4096) entries;
// with n zero the scan is skipped, and with replication zero the block stays idle.
// The table memory is read one entry per cycle through a five-stage distance pipeline into
// the ranked list, and the ranks leave one per accepted result.
// Reset is synchronous and active low; the table memory is not cleared.
// A stalled result holds the block, and no item is accepted until the query is done.
`default_nettype none
`include "nearest_point_top_k_select_macros.svh"

module nearest_point_top_k_select (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic                      in_action,
  input  wire logic [11:0]               in_entry_index,
  input  wire logic [15:0]               in_entry_server,
  input  wire logic [63:0]               in_entry_point,
  input  wire logic [63:0]               in_object_point,
  input  wire logic [3:0]                in_replication,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic [15:0]                    out_server_index,
  output logic                           out_found,
  output logic [2:0]                     out_rank,
  output logic                           out_last,
  input  wire logic                      cfg_we,
  input  wire logic [12:0]               cfg_wdata
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  logic [1:0]          state_r, state_nxt;
  nptk_pkg::count_t    entries_r;
  nptk_pkg::count_t    count_r;
  nptk_pkg::count_t    scan_idx_r;
  nptk_pkg::rep_t      rep_r;
  nptk_pkg::point_t    obj_r;
  nptk_pkg::slot_t     emit_idx_r;

  logic                in_acc, out_acc, query_start, ram_we, scan_issue, pipe_busy;
  logic [nptk_pkg::ENTRY_W-1:0] ram_wdata, ram_rdata;
  nptk_pkg::count_t    count_sat;
  nptk_pkg::rep_t      rep_sat;

  logic                rd_v_r, ad_v_r, mx_v_r, my_v_r, ds_v_r;
  nptk_pkg::coord_t    dx_r, dy_r, dy_m_r;
  nptk_pkg::coord_t    dx_nxt, dy_nxt;
  nptk_pkg::coord_t    ax, bx, ay, by;
  nptk_pkg::server_t   srv_a_r, srv_m_r, srv_y_r, srv_d_r;
  nptk_pkg::point_t    sx_r, sx_y_r, sy_r;
  nptk_pkg::dist_t     dist_r;

  nptk_pkg::dist_t     best_d_r   [nptk_pkg::MAX_COPIES];
  nptk_pkg::server_t   best_s_r   [nptk_pkg::MAX_COPIES];
  nptk_pkg::dist_t     best_d_nxt [nptk_pkg::MAX_COPIES];
  nptk_pkg::server_t   best_s_nxt [nptk_pkg::MAX_COPIES];
  logic [nptk_pkg::MAX_COPIES-1:0] best_filled_r, best_filled_nxt;
  logic [nptk_pkg::MAX_COPIES-1:0] act, cand, eq;
  nptk_pkg::server_t   head_s [nptk_pkg::MAX_COPIES];
  logic                hit;
  nptk_pkg::slot_t     pos;

  assign in_stall    = (state_r != ST_IDLE);
  assign in_acc      = in_valid && !in_stall;
  assign query_start = in_acc && (in_action == nptk_pkg::ACT_QUERY);
  assign ram_we      = in_acc && (in_action == nptk_pkg::ACT_LOAD);
  assign ram_wdata   = {in_entry_server, in_entry_point};
  assign scan_issue  = (state_r == ST_SCAN);
  assign pipe_busy   = rd_v_r || ad_v_r || mx_v_r || my_v_r || ds_v_r;

  assign count_sat = (entries_r > nptk_pkg::count_t'(nptk_pkg::TABLE_DEPTH)) ?
                     nptk_pkg::count_t'(nptk_pkg::TABLE_DEPTH) : entries_r;
  assign rep_sat   = (in_replication > nptk_pkg::rep_t'(nptk_pkg::MAX_COPIES)) ?
                     nptk_pkg::rep_t'(nptk_pkg::MAX_COPIES) : in_replication;

  nptk_ram #(
    .WIDTH (nptk_pkg::ENTRY_W),
    .DEPTH (nptk_pkg::TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (in_entry_index),
    .wdata (ram_wdata),
    .raddr (scan_idx_r[nptk_pkg::ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  // Distance pipeline.
  always_comb begin
    ax = ram_rdata[nptk_pkg::COORD_W-1:0];
    ay = ram_rdata[nptk_pkg::POINT_W-1:nptk_pkg::COORD_W];
    bx = obj_r[nptk_pkg::COORD_W-1:0];
    by = obj_r[nptk_pkg::POINT_W-1:nptk_pkg::COORD_W];
    dx_nxt = (ax >= bx) ? (ax - bx) : (bx - ax);
    dy_nxt = (ay >= by) ? (ay - by) : (by - ay);
  end

  always_ff @(posedge clk) begin
    dx_r    <= dx_nxt;
    dy_r    <= dy_nxt;
    srv_a_r <= ram_rdata[nptk_pkg::ENTRY_W-1:nptk_pkg::POINT_W];
    sx_r    <= nptk_pkg::POINT_W'(dx_r) * nptk_pkg::POINT_W'(dx_r);
    dy_m_r  <= dy_r;
    srv_m_r <= srv_a_r;
    sx_y_r  <= sx_r;
    sy_r    <= nptk_pkg::POINT_W'(dy_m_r) * nptk_pkg::POINT_W'(dy_m_r);
    srv_y_r <= srv_m_r;
    dist_r  <= nptk_pkg::DIST_W'(sx_y_r) + nptk_pkg::DIST_W'(sy_r);
    srv_d_r <= srv_y_r;
  end

  // Ranked list insertion. The displaced entry of each run of equal distances
  // moves to the first slot after that run.
  always_comb begin
    eq[0]     = 1'b0;
    head_s[0] = best_s_r[0];
    for (int k = 1; k < nptk_pkg::MAX_COPIES; k++) begin
      eq[k]     = (best_d_r[k] == best_d_r[k-1]);
      head_s[k] = eq[k] ? head_s[k-1] : best_s_r[k];
    end
    hit = 1'b0;
    pos = '0;
    for (int k = 0; k < nptk_pkg::MAX_COPIES; k++) begin
      act[k]  = (nptk_pkg::rep_t'(k) < rep_r);
      cand[k] = act[k] && (!best_filled_r[k] || (dist_r < best_d_r[k]));
      if (cand[k] && !hit) begin
        hit = 1'b1;
        pos = nptk_pkg::slot_t'(k);
      end
    end
    for (int k = 0; k < nptk_pkg::MAX_COPIES; k++) begin
      best_d_nxt[k]      = best_d_r[k];
      best_s_nxt[k]      = best_s_r[k];
      best_filled_nxt[k] = best_filled_r[k];
    end
    if (ds_v_r && hit) begin
      best_d_nxt[pos]      = dist_r;
      best_s_nxt[pos]      = srv_d_r;
      best_filled_nxt[pos] = 1'b1;
      for (int k = 1; k < nptk_pkg::MAX_COPIES; k++) begin
        if (act[k] && (nptk_pkg::slot_t'(k) > pos) && best_filled_r[k-1] &&
            (!best_filled_r[k] || !eq[k])) begin
          best_d_nxt[k]      = best_d_r[k-1];
          best_s_nxt[k]      = head_s[k-1];
          best_filled_nxt[k] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < nptk_pkg::MAX_COPIES; k++) begin
      best_d_r[k] <= best_d_nxt[k];
      best_s_r[k] <= best_s_nxt[k];
    end
  end

  // Control.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (query_start && (rep_sat != '0)) begin
          state_nxt = (count_sat == '0) ? ST_DRAIN : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if ((scan_idx_r + nptk_pkg::count_t'(1)) == count_r) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!pipe_busy) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_acc && out_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      entries_r     <= '0;
      count_r       <= '0;
      scan_idx_r    <= '0;
      rep_r         <= '0;
      emit_idx_r    <= '0;
      best_filled_r <= '0;
      rd_v_r        <= 1'b0;
      ad_v_r        <= 1'b0;
      mx_v_r        <= 1'b0;
      my_v_r        <= 1'b0;
      ds_v_r        <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rd_v_r  <= scan_issue;
      ad_v_r  <= rd_v_r;
      mx_v_r  <= ad_v_r;
      my_v_r  <= mx_v_r;
      ds_v_r  <= my_v_r;
      if (cfg_we) begin
        entries_r <= cfg_wdata;
      end
      if (query_start) begin
        count_r       <= count_sat;
        rep_r         <= rep_sat;
        scan_idx_r    <= '0;
        emit_idx_r    <= '0;
        best_filled_r <= '0;
      end else begin
        best_filled_r <= best_filled_nxt;
        if (scan_issue) begin
          scan_idx_r <= scan_idx_r + nptk_pkg::count_t'(1);
        end
        if (out_acc) begin
          emit_idx_r <= emit_idx_r + nptk_pkg::slot_t'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (query_start) begin
      obj_r <= in_object_point;
    end
  end

  // Result channel.
  assign out_valid        = (state_r == ST_EMIT);
  assign out_acc          = out_valid && !out_stall;
  assign out_found        = best_filled_r[emit_idx_r];
  assign out_server_index = out_found ? best_s_r[emit_idx_r] : '0;
  assign out_rank         = emit_idx_r;
  assign out_last         = ((nptk_pkg::rep_t'(emit_idx_r) + nptk_pkg::rep_t'(1)) == rep_r);

  `NPTK_ASSERT_SAME(a_scan_in_range, state_r == ST_SCAN, scan_idx_r < count_r, "scan index beyond count")
  `NPTK_ASSERT_SAME(a_emit_drained, out_valid, !pipe_busy, "result shown while pipeline busy")
  `NPTK_ASSERT_SAME(a_filled_prefix, 1'b1, ((best_filled_r & (best_filled_r + 1'b1)) == '0) && ($countones(best_filled_r) <= rep_r), "ranked list not a prefix")
  `NPTK_ASSERT_NEXT(a_query_starts, query_start && (rep_sat != '0), (state_r == ST_SCAN) || (state_r == ST_DRAIN), "query did not start")

endmodule

`default_nettype wire
